### rtl/brc_pkg.sv
`timescale 1ns / 1ps

package brc_pkg;

  localparam int MAX_ANGLES_DEF  = 64;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int CORDIC_STEPS    = 24;

  // Widths of the datapath: CORDIC coordinates, CORDIC angle (Q30),
  // wrapped angles (Q12), cost, and the to-index dividend.
  localparam int XW = 34;
  localparam int ZW = 36;
  localparam int AW = 19;
  localparam int CW = 15;
  localparam int DW = 17;

  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint PI_FIX = (PI_Q30 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS)))
                              >>> (30 - ANGLE_FRAC_BITS);

  localparam logic [CW-1:0] COST_MAX = 15'h7FFF;

  localparam logic [1:0] MODE_CELL = 2'd0;
  localparam logic [1:0] MODE_DIST = 2'd1;

  localparam logic [2:0] REG_HEADING_MODE      = 3'd0;
  localparam logic [2:0] REG_HEADING_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_ANGLE_COUNT       = 3'd2;
  localparam logic [2:0] REG_ANGLE_STEP        = 3'd3;
  localparam logic [2:0] REG_DISCRETE_RESULT   = 3'd4;
  localparam logic [2:0] REG_ROTATION_DEADBAND = 3'd5;

  // Truncated atan(2^-i) in Q30.
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 36'sd843314856;
      1: v = 36'sd497837829;
      2: v = 36'sd263043836;
      3: v = 36'sd133525158;
      4: v = 36'sd67021686;
      5: v = 36'sd33543515;
      6: v = 36'sd16775850;
      7: v = 36'sd8388437;
      8: v = 36'sd4194282;
      9: v = 36'sd2097149;
      10: v = 36'sd1048575;
      11: v = 36'sd524287;
      12: v = 36'sd262143;
      13: v = 36'sd131071;
      14: v = 36'sd65535;
      15: v = 36'sd32767;
      16: v = 36'sd16383;
      17: v = 36'sd8191;
      18: v = 36'sd4095;
      19: v = 36'sd2047;
      20: v = 36'sd1023;
      21: v = 36'sd511;
      22: v = 36'sd255;
      23: v = 36'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/brc_cordic_cell.sv
`timescale 1ns / 1ps

module brc_cordic_cell #(
  parameter int SHIFT = 0,
  parameter int PW    = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic signed [brc_pkg::XW-1:0] in_x,
  input  logic signed [brc_pkg::XW-1:0] in_y,
  input  logic signed [brc_pkg::ZW-1:0] in_z,
  input  logic [PW-1:0]                in_pay,
  output logic                         out_valid,
  output logic signed [brc_pkg::XW-1:0] out_x,
  output logic signed [brc_pkg::XW-1:0] out_y,
  output logic signed [brc_pkg::ZW-1:0] out_z,
  output logic [PW-1:0]                out_pay
);
  import brc_pkg::*;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign xs = in_x >>> SHIFT;
  assign ys = in_y >>> SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    if (in_y > 0) begin
      out_x <= in_x + ys;
      out_y <= in_y - xs;
      out_z <= in_z + atan_q30(SHIFT);
    end else begin
      out_x <= in_x - ys;
      out_y <= in_y + xs;
      out_z <= in_z - atan_q30(SHIFT);
    end
    out_pay <= in_pay;
  end

endmodule

### rtl/brc_div_cell.sv
`timescale 1ns / 1ps

// One restoring step per cell: the partial remainder takes the next dividend
// bit, and the quotient bit shifts into the low end of the dividend register.
module brc_div_cell #(
  parameter int NUMW  = 17,
  parameter int VW    = 16,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [LANES*NUMW-1:0] in_a,
  input  logic [LANES*VW-1:0]   in_r,
  input  logic [VW-1:0]         in_d,
  input  logic [PW-1:0]         in_pay,
  output logic                  out_valid,
  output logic [LANES*NUMW-1:0] out_a,
  output logic [LANES*VW-1:0]   out_r,
  output logic [PW-1:0]         out_pay
);

  logic [LANES*NUMW-1:0] a_next;
  logic [LANES*VW-1:0]   r_next;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [NUMW-1:0] a;
    logic [VW-1:0]   r;
    logic [VW:0]     t;
    logic [VW:0]     diff;
    logic            ge;

    assign a    = in_a[l*NUMW +: NUMW];
    assign r    = in_r[l*VW +: VW];
    assign t    = {r, a[NUMW-1]};
    assign diff = t - {1'b0, in_d};
    assign ge   = t >= {1'b0, in_d};
    assign a_next[l*NUMW +: NUMW] = {a[NUMW-2:0], ge};
    assign r_next[l*VW +: VW]     = ge ? diff[VW-1:0] : t[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_a   <= a_next;
    out_r   <= r_next;
    out_pay <= in_pay;
  end

endmodule

### rtl/base_rotation_cost.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// input     start, busy             src_index .. turn_steps
// result    done                    rotation_cost
// config    psel/penable/pwrite     paddr, pwdata, prdata, pready
//
// One item enters every cycle; busy stays low. Each result is registered through
// a row of 24 CORDIC cells for atan2, then a row of 17 divider cells for the
// heading index and a row of 17 divider cells for the reductions modulo
// angle_count (capped at MAX_ANGLES), plus the stages around them.
// Reset (rst, synchronous) restores the register defaults and empties the pipe.
// The receiver cannot stall: done is a one-cycle strobe.
module base_rotation_cost #(
  parameter int MAX_ANGLES = brc_pkg::MAX_ANGLES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [5:0]         src_index,
  input  logic [5:0]         dst_index,
  input  logic signed [15:0] src_angle,
  input  logic signed [15:0] dst_angle,
  input  logic signed [15:0] offset_x,
  input  logic signed [15:0] offset_y,
  input  logic [13:0]        turn_angle,
  input  logic signed [15:0] cell_dx,
  input  logic signed [15:0] cell_dy,
  input  logic [5:0]         turn_steps,
  output logic               done,
  output logic [14:0]        rotation_cost,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import brc_pkg::*;

  localparam int NW  = $clog2(MAX_ANGLES + 1);
  localparam int KW  = (NW + 1 > 6) ? NW + 1 : 6;
  localparam int PRW = CW + KW;
  localparam int ZSH = 30 - ANGLE_FRAC_BITS;
  localparam int LAT = 1 + CORDIC_STEPS + 5 + DW + 1 + DW + 4 + 1;
  localparam logic signed [AW-1:0] PI_A     = AW'(PI_FIX);
  localparam logic signed [AW-1:0] TWO_PI_A = AW'(2 * PI_FIX);

  typedef struct packed {
    logic [5:0]         src_i;
    logic [5:0]         dst_i;
    logic [5:0]         turn_s;
    logic [13:0]        turn_a;
    logic signed [15:0] src_a;
    logic signed [15:0] dst_a;
    logic               add;
    logic               zero;
    logic [CW-1:0]      cont;
  } pay_t;

  localparam int PW = $bits(pay_t);

  // Configuration registers.
  logic [1:0]  heading_mode;
  logic [14:0] heading_threshold;
  logic [6:0]  angle_count;
  logic [14:0] angle_step;
  logic        discrete_result;
  logic [14:0] rotation_deadband;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign busy      = 1'b0;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      heading_mode      <= 2'd0;
      heading_threshold <= 15'd0;
      angle_count       <= 7'd16;
      angle_step        <= 15'd1608;
      discrete_result   <= 1'b1;
      rotation_deadband <= 15'd0;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_HEADING_MODE:      heading_mode      <= pwdata[1:0];
        REG_HEADING_THRESHOLD: heading_threshold <= pwdata[14:0];
        REG_ANGLE_COUNT:       angle_count       <= pwdata[6:0];
        REG_ANGLE_STEP:        angle_step        <= pwdata[14:0];
        REG_DISCRETE_RESULT:   discrete_result   <= pwdata[0];
        REG_ROTATION_DEADBAND: rotation_deadband <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_HEADING_MODE:      prdata = {30'd0, heading_mode};
      REG_HEADING_THRESHOLD: prdata = {17'd0, heading_threshold};
      REG_ANGLE_COUNT:       prdata = {25'd0, angle_count};
      REG_ANGLE_STEP:        prdata = {17'd0, angle_step};
      REG_DISCRETE_RESULT:   prdata = {31'd0, discrete_result};
      REG_ROTATION_DEADBAND: prdata = {17'd0, rotation_deadband};
      default:               prdata = 32'd0;
    endcase
  end

  logic [NW-1:0] n;
  logic [NW-1:0] half_n;

  always_comb begin
    if (int'(angle_count) > MAX_ANGLES) begin
      n = NW'(MAX_ANGLES);
    end else begin
      n = NW'(angle_count);
    end
  end
  assign half_n = n >> 1;

  function automatic logic signed [AW-1:0] wrap(input logic signed [AW-1:0] d);
    logic signed [AW-1:0] m;
    if (d >= 2 * TWO_PI_A) begin
      m = d - 2 * TWO_PI_A;
    end else if (d >= TWO_PI_A) begin
      m = d - TWO_PI_A;
    end else if (d >= 0) begin
      m = d;
    end else if (d >= -TWO_PI_A) begin
      m = d + TWO_PI_A;
    end else if (d >= -2 * TWO_PI_A) begin
      m = d + 2 * TWO_PI_A;
    end else begin
      m = d + 3 * TWO_PI_A;
    end
    return m;
  endfunction

  function automatic logic signed [AW-1:0] fold(input logic signed [AW-1:0] d);
    logic signed [AW-1:0] m;
    m = wrap(d);
    if (m > PI_A) begin
      m = TWO_PI_A - m;
    end
    return m;
  endfunction

  // Both arguments are already reduced modulo nn.
  function automatic logic [NW-1:0] idist(input logic [NW-1:0] a, input logic [NW-1:0] b,
                                          input logic [NW-1:0] nn);
    logic [NW:0] r;
    logic [NW:0] nr;
    logic [NW:0] m;
    if (a >= b) begin
      r = {1'b0, a} - {1'b0, b};
    end else begin
      r = {1'b0, a} + {1'b0, nn} - {1'b0, b};
    end
    nr = {1'b0, nn} - r;
    m  = (r < nr) ? r : nr;
    if (nn == '0) begin
      m = '0;
    end
    return m[NW-1:0];
  endfunction

  // Input stage with the squares for the distance test.
  logic               f0_valid;
  pay_t               f0_pay;
  logic signed [15:0] f0_ox;
  logic signed [15:0] f0_oy;
  logic               f0_cdnz;
  logic [31:0]        f0_sqx;
  logic [31:0]        f0_sqy;
  logic [29:0]        f0_sqt;

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
    end else begin
      f0_valid <= start && !busy;
    end
    f0_pay.src_i  <= src_index;
    f0_pay.dst_i  <= dst_index;
    f0_pay.turn_s <= turn_steps;
    f0_pay.turn_a <= turn_angle;
    f0_pay.src_a  <= src_angle;
    f0_pay.dst_a  <= dst_angle;
    f0_pay.add    <= 1'b0;
    f0_pay.zero   <= 1'b0;
    f0_pay.cont   <= '0;
    f0_ox         <= offset_x;
    f0_oy         <= offset_y;
    f0_cdnz       <= (cell_dx != 16'sd0) || (cell_dy != 16'sd0);
    f0_sqx        <= 32'(32'(offset_x) * 32'(offset_x));
    f0_sqy        <= 32'(32'(offset_y) * 32'(offset_y));
    f0_sqt        <= heading_threshold * heading_threshold;
  end

  // Heading test and the CORDIC preparation.
  pay_t                 pay_in;
  logic signed [XW-1:0] xa;
  logic signed [XW-1:0] ya;
  logic signed [ZW-1:0] za;

  always_comb begin
    pay_in = f0_pay;
    case (heading_mode)
      MODE_CELL: pay_in.add = f0_cdnz;
      MODE_DIST: pay_in.add = ({1'b0, f0_sqx} + {1'b0, f0_sqy}) > {3'd0, f0_sqt};
      default:   pay_in.add = 1'b0;
    endcase
    pay_in.zero = (f0_ox == 16'sd0) && (f0_oy == 16'sd0);
    xa = XW'(f0_ox);
    ya = XW'(f0_oy);
    za = '0;
    if (f0_ox < 0) begin
      // Turn a left-half vector by half a circle so that the iterations converge.
      za = (f0_oy >= 0) ? ZW'(PI_Q30) : -ZW'(PI_Q30);
      xa = -xa;
      ya = -ya;
    end
    xa = xa <<< 14;
    ya = ya <<< 14;
  end

  logic                 cv [0:CORDIC_STEPS];
  logic signed [XW-1:0] cx [0:CORDIC_STEPS];
  logic signed [XW-1:0] cy [0:CORDIC_STEPS];
  logic signed [ZW-1:0] cz [0:CORDIC_STEPS];
  logic [PW-1:0]        cp [0:CORDIC_STEPS];

  assign cv[0] = f0_valid;
  assign cx[0] = xa;
  assign cy[0] = ya;
  assign cz[0] = za;
  assign cp[0] = pay_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    brc_cordic_cell #(
      .SHIFT (i),
      .PW    (PW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_z      (cz[i]),
      .in_pay    (cp[i]),
      .out_valid (cv[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_z     (cz[i+1]),
      .out_pay   (cp[i+1])
    );
  end

  // Post-CORDIC stages: heading, wrapped differences, continuous cost.
  pay_t                 c_pay;
  logic signed [ZW-1:0] z_round;

  assign c_pay   = pay_t'(cp[CORDIC_STEPS]);
  assign z_round = cz[CORDIC_STEPS] + ZW'(64'sd1 <<< (ZSH - 1));

  logic                 p1_valid;
  pay_t                 p1_pay;
  logic signed [AW-1:0] p1_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= cv[CORDIC_STEPS];
    end
    p1_pay <= c_pay;
    p1_h   <= c_pay.zero ? '0 : AW'(z_round >>> ZSH);
  end

  logic                 p2_valid;
  pay_t                 p2_pay;
  logic signed [AW-1:0] p2_h;
  logic signed [AW-1:0] p2_hb;
  logic signed [AW-1:0] p2_hw;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid;
    end
    p2_pay <= p1_pay;
    p2_h   <= p1_h;
    p2_hb  <= p1_h + PI_A;
    p2_hw  <= wrap(p1_h);
  end

  logic                 p3_valid;
  pay_t                 p3_pay;
  logic [DW-1:0]        p3_num;
  logic signed [AW-1:0] p3_d [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
    p3_pay  <= p2_pay;
    p3_num  <= DW'({p2_hw[14:0], 1'b0}) + DW'(angle_step);
    p3_d[0] <= AW'(p2_pay.src_a) - p2_h;
    p3_d[1] <= p2_h - AW'(p2_pay.dst_a);
    p3_d[2] <= AW'(p2_pay.src_a) - p2_hb;
    p3_d[3] <= p2_hb - AW'(p2_pay.dst_a);
  end

  logic                 p4_valid;
  pay_t                 p4_pay;
  logic [DW-1:0]        p4_num;
  logic signed [AW-1:0] p4_m [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else begin
      p4_valid <= p3_valid;
    end
    p4_pay <= p3_pay;
    p4_num <= p3_num;
    for (int j = 0; j < 4; j++) begin
      p4_m[j] <= fold(p3_d[j]);
    end
  end

  logic                 p5_valid;
  pay_t                 p5_pay;
  pay_t                 p5_pay_next;
  logic [DW-1:0]        p5_num;
  logic signed [AW-1:0] cont_sum;
  logic [CW-1:0]        cont_cost;

  always_comb begin
    // Forward facing wins only when its turn from the source angle is strictly shorter.
    cont_sum = (p4_m[0] < p4_m[2]) ? p4_m[0] + p4_m[1] : p4_m[2] + p4_m[3];
    if (p4_pay.add) begin
      cont_cost = cont_sum[CW-1:0];
    end else begin
      cont_cost = CW'(p4_pay.turn_a);
    end
    if (cont_cost < rotation_deadband) begin
      cont_cost = '0;
    end
    p5_pay_next      = p4_pay;
    p5_pay_next.cont = cont_cost;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_valid <= 1'b0;
    end else begin
      p5_valid <= p4_valid;
    end
    p5_pay <= p5_pay_next;
    p5_num <= p4_num;
  end

  // Heading index: (2*heading + step) / (2*step).
  logic          d1v [0:DW];
  logic [DW-1:0] d1a [0:DW];
  logic [15:0]   d1r [0:DW];
  logic [PW-1:0] d1p [0:DW];

  assign d1v[0] = p5_valid;
  assign d1a[0] = p5_num;
  assign d1r[0] = '0;
  assign d1p[0] = p5_pay;

  for (genvar i = 0; i < DW; i++) begin : g_div_index
    brc_div_cell #(
      .NUMW  (DW),
      .VW    (16),
      .LANES (1),
      .PW    (PW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (d1v[i]),
      .in_a      (d1a[i]),
      .in_r      (d1r[i]),
      .in_d      ({angle_step, 1'b0}),
      .in_pay    (d1p[i]),
      .out_valid (d1v[i+1]),
      .out_a     (d1a[i+1]),
      .out_r     (d1r[i+1]),
      .out_pay   (d1p[i+1])
    );
  end

  logic          q1_valid;
  pay_t          q1_pay;
  logic [DW-1:0] q1_hf;

  always_ff @(posedge clk) begin
    if (rst) begin
      q1_valid <= 1'b0;
    end else begin
      q1_valid <= d1v[DW];
    end
    q1_pay <= pay_t'(d1p[DW]);
    q1_hf  <= (angle_step == 15'd0) ? '0 : d1a[DW];
  end

  // Reduction of the heading index and both pose indices modulo n.
  logic            d2v [0:DW];
  logic [3*DW-1:0] d2a [0:DW];
  logic [3*NW-1:0] d2r [0:DW];
  logic [PW-1:0]   d2p [0:DW];

  assign d2v[0] = q1_valid;
  assign d2a[0] = {DW'(q1_pay.dst_i), DW'(q1_pay.src_i), q1_hf};
  assign d2r[0] = '0;
  assign d2p[0] = q1_pay;

  for (genvar i = 0; i < DW; i++) begin : g_div_mod
    brc_div_cell #(
      .NUMW  (DW),
      .VW    (NW),
      .LANES (3),
      .PW    (PW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (d2v[i]),
      .in_a      (d2a[i]),
      .in_r      (d2r[i]),
      .in_d      (n),
      .in_pay    (d2p[i]),
      .out_valid (d2v[i+1]),
      .out_a     (d2a[i+1]),
      .out_r     (d2r[i+1]),
      .out_pay   (d2p[i+1])
    );
  end

  logic          q2_valid;
  pay_t          q2_pay;
  logic [NW-1:0] q2_rf;
  logic [NW-1:0] q2_rs;
  logic [NW-1:0] q2_rd;
  logic [NW-1:0] q2_rb;
  logic [NW:0]   rb_sum;

  assign rb_sum = {1'b0, d2r[DW][NW-1:0]} + {1'b0, half_n};

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_valid <= 1'b0;
    end else begin
      q2_valid <= d2v[DW];
    end
    q2_pay <= pay_t'(d2p[DW]);
    q2_rf  <= d2r[DW][NW-1:0];
    q2_rs  <= d2r[DW][2*NW-1:NW];
    q2_rd  <= d2r[DW][3*NW-1:2*NW];
    q2_rb  <= (rb_sum >= {1'b0, n}) ? NW'(rb_sum - {1'b0, n}) : rb_sum[NW-1:0];
  end

  logic          q3_valid;
  pay_t          q3_pay;
  logic [NW-1:0] q3_e [0:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      q3_valid <= 1'b0;
    end else begin
      q3_valid <= q2_valid;
    end
    q3_pay  <= q2_pay;
    q3_e[0] <= idist(q2_rs, q2_rf, n);
    q3_e[1] <= idist(q2_rf, q2_rd, n);
    q3_e[2] <= idist(q2_rb, q2_rs, n);
    q3_e[3] <= idist(q2_rb, q2_rd, n);
  end

  logic          q4_valid;
  pay_t          q4_pay;
  logic [KW-1:0] q4_k;
  logic [NW:0]   k_sum;

  assign k_sum = (q3_e[0] < q3_e[2]) ? {1'b0, q3_e[0]} + {1'b0, q3_e[1]}
                                     : {1'b0, q3_e[2]} + {1'b0, q3_e[3]};

  always_ff @(posedge clk) begin
    if (rst) begin
      q4_valid <= 1'b0;
    end else begin
      q4_valid <= q3_valid;
    end
    q4_pay <= q3_pay;
    q4_k   <= q3_pay.add ? KW'(k_sum) : KW'(q3_pay.turn_s);
  end

  logic           q5_valid;
  pay_t           q5_pay;
  logic [PRW-1:0] q5_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      q5_valid <= 1'b0;
    end else begin
      q5_valid <= q4_valid;
    end
    q5_pay  <= q4_pay;
    q5_prod <= PRW'(angle_step) * PRW'(q4_k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q5_valid;
    end
    if (discrete_result) begin
      rotation_cost <= (q5_prod > PRW'(COST_MAX)) ? COST_MAX : q5_prod[CW-1:0];
    end else begin
      rotation_cost <= q5_pay.cont;
    end
  end

  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobe without an accepted item");

  a_mod_below_n: assert property (@(posedge clk) disable iff (rst)
    (q2_valid && n != '0) |-> (q2_rf < n && q2_rs < n && q2_rd < n && q2_rb < n))
    else $error("index reduction left a value not below angle_count");

  a_index_dist_half: assert property (@(posedge clk) disable iff (rst)
    q3_valid |-> (q3_e[0] <= half_n && q3_e[1] <= half_n &&
                  q3_e[2] <= half_n && q3_e[3] <= half_n))
    else $error("index distance beyond half a circle");

  a_angle_dist_pi: assert property (@(posedge clk) disable iff (rst)
    p4_valid |-> (p4_m[0] >= 0 && p4_m[0] <= PI_A && p4_m[2] >= 0 && p4_m[2] <= PI_A))
    else $error("angle distance outside zero to pi");

endmodule
